[rtl/core/ray_triangle_intersect_top_defines.svh]
// Assertion macros used by the checker file of the ray/triangle block.
`ifndef RAY_TRIANGLE_INTERSECT_TOP_DEFINES_SVH
`define RAY_TRIANGLE_INTERSECT_TOP_DEFINES_SVH

// Condition implies consequence in the same cycle, held off during reset.
`define RTI_ASSERT_NOW(lbl, clk, rst_n, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("ray/triangle check failed");

// Condition implies consequence in the next cycle, held off during reset.
`define RTI_ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("ray/triangle check failed");

// Check that also runs across reset.
`define RTI_ASSERT_ALWAYS(lbl, clk, cond, cons) \
  lbl: assert property (@(posedge clk) (cond) |=> (cons)) \
    else $error("ray/triangle check failed");

`endif

[rtl/core/rti_pkg.sv]
package rti_pkg;

  localparam int FIELD_W       = 16;
  localparam int TAG_W         = 32;
  localparam int DIST_W        = 32;
  localparam int BARY_W        = 17;
  localparam int CFG_ADDR_W    = 3;
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // Register indices of the configuration port
  localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_DIR_X    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_DIR_Y    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_DIR_Z    = 3'd5;

  typedef struct packed {
    logic signed [FIELD_W-1:0] vert_a_x;
    logic signed [FIELD_W-1:0] vert_a_y;
    logic signed [FIELD_W-1:0] vert_a_z;
    logic signed [FIELD_W-1:0] vert_b_x;
    logic signed [FIELD_W-1:0] vert_b_y;
    logic signed [FIELD_W-1:0] vert_b_z;
    logic signed [FIELD_W-1:0] vert_c_x;
    logic signed [FIELD_W-1:0] vert_c_y;
    logic signed [FIELD_W-1:0] vert_c_z;
    logic [TAG_W-1:0]          face_tag;
  } in_word_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] hit_distance;
    logic [BARY_W-1:0] bary_u;
    logic [BARY_W-1:0] bary_v;
    logic [BARY_W-1:0] bary_w;
    logic              back_facing;
    logic [TAG_W-1:0]  face_tag_out;
  } out_word_t;

  // Per-word control travelling alongside the data path
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic             sat;
    logic             back;
    logic [TAG_W-1:0] tag;
  } side_t;

endpackage

[rtl/core/ray_triangle_intersect_top.sv]
// Two-sided ray/triangle test, one triangle word per clock while the output is
// not held. The ray is held in six configuration registers; each input word
// carries a triangle and a tag and yields exactly one result word. Seven stages
// form the edge vectors, the normal, the denominator and the three numerators and
// do the exact hit test; a 32-stage restoring divider, one quotient bit per stage,
// then gives t, v and w in parallel. The whole pipeline advances together: it
// holds only while the output register is full and not taken, so throughput is
// one word per cycle.
module ray_triangle_intersect_top #(
  parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = rti_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rti_pkg::in_word_t                 in_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rti_pkg::out_word_t                out_word,
  input  logic                              cfg_we,
  input  logic [rti_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [rti_pkg::FIELD_W-1:0]       cfg_wdata
);
  import rti_pkg::*;

  localparam int CW     = COORD_BITS + 1;
  localparam int PW     = 2 * CW;
  localparam int NW     = PW + 1;
  localparam int MW     = CW + NW;
  localparam int SW     = MW + 2;
  localparam int RW     = SW + DIST_W;
  localparam int SAT_SH = DIST_W - FRAC_BITS;
  localparam int NSTG   = DIST_W;
  localparam logic [BARY_W-1:0] ONE_Q = BARY_W'(1 << FRAC_BITS);

  logic adv;

  // ---------------- configuration ----------------
  logic [FIELD_W-1:0] cfg_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) cfg_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ORIGIN_X: cfg_r[0] <= cfg_wdata;
        CFG_ORIGIN_Y: cfg_r[1] <= cfg_wdata;
        CFG_ORIGIN_Z: cfg_r[2] <= cfg_wdata;
        CFG_DIR_X:    cfg_r[3] <= cfg_wdata;
        CFG_DIR_Y:    cfg_r[4] <= cfg_wdata;
        CFG_DIR_Z:    cfg_r[5] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sign-extend the low COORD_BITS bits to the difference width
  function automatic logic signed [CW-1:0] sx(input logic [FIELD_W-1:0] v);
    sx = signed'({{(CW-COORD_BITS){v[COORD_BITS-1]}}, v[COORD_BITS-1:0]});
  endfunction

  // ---------------- stage 1: edge vectors ----------------
  logic signed [CW-1:0] ab_nxt [3], ac_nxt [3], p_nxt [3], q_nxt [3];
  logic signed [CW-1:0] a_c [3], b_c [3], c_c [3];
  logic signed [CW-1:0] ab1_r [3], ac1_r [3], p1_r [3], q1_r [3];
  side_t s1_nxt, s1_r;

  always_comb begin
    a_c[0] = sx(in_word.vert_a_x);
    a_c[1] = sx(in_word.vert_a_y);
    a_c[2] = sx(in_word.vert_a_z);
    b_c[0] = sx(in_word.vert_b_x);
    b_c[1] = sx(in_word.vert_b_y);
    b_c[2] = sx(in_word.vert_b_z);
    c_c[0] = sx(in_word.vert_c_x);
    c_c[1] = sx(in_word.vert_c_y);
    c_c[2] = sx(in_word.vert_c_z);
    for (int i = 0; i < 3; i++) begin
      ab_nxt[i] = b_c[i] - a_c[i];
      ac_nxt[i] = c_c[i] - a_c[i];
      p_nxt[i]  = sx(cfg_r[i]) - a_c[i];
      q_nxt[i]  = -sx(cfg_r[3+i]);
    end
    s1_nxt       = '0;
    s1_nxt.valid = in_valid;
    s1_nxt.tag   = in_word.face_tag;
  end

  // ---------------- stage 2: cross-product terms ----------------
  logic signed [PW-1:0] np_nxt [3][2], ep_nxt [3][2];
  logic signed [PW-1:0] np2_r [3][2], ep2_r [3][2];
  logic signed [CW-1:0] ab2_r [3], ac2_r [3], p2_r [3], q2_r [3];
  side_t s2_r;

  always_comb begin
    np_nxt[0][0] = PW'(ab1_r[1]) * PW'(ac1_r[2]);
    np_nxt[0][1] = PW'(ab1_r[2]) * PW'(ac1_r[1]);
    np_nxt[1][0] = PW'(ab1_r[2]) * PW'(ac1_r[0]);
    np_nxt[1][1] = PW'(ab1_r[0]) * PW'(ac1_r[2]);
    np_nxt[2][0] = PW'(ab1_r[0]) * PW'(ac1_r[1]);
    np_nxt[2][1] = PW'(ab1_r[1]) * PW'(ac1_r[0]);
    ep_nxt[0][0] = PW'(q1_r[1]) * PW'(p1_r[2]);
    ep_nxt[0][1] = PW'(q1_r[2]) * PW'(p1_r[1]);
    ep_nxt[1][0] = PW'(q1_r[2]) * PW'(p1_r[0]);
    ep_nxt[1][1] = PW'(q1_r[0]) * PW'(p1_r[2]);
    ep_nxt[2][0] = PW'(q1_r[0]) * PW'(p1_r[1]);
    ep_nxt[2][1] = PW'(q1_r[1]) * PW'(p1_r[0]);
  end

  // ---------------- stage 3: normal and e ----------------
  logic signed [NW-1:0] n_nxt [3], e_nxt [3];
  logic signed [NW-1:0] n3_r [3], e3_r [3];
  logic signed [CW-1:0] ab3_r [3], ac3_r [3], p3_r [3], q3_r [3];
  side_t s3_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_nxt[i] = NW'(np2_r[i][0]) - NW'(np2_r[i][1]);
      e_nxt[i] = NW'(ep2_r[i][0]) - NW'(ep2_r[i][1]);
    end
  end

  // ---------------- stage 4: dot-product terms ----------------
  logic signed [MW-1:0] dm_nxt [3], tm_nxt [3], vm_nxt [3], wm_nxt [3];
  logic signed [MW-1:0] dm4_r [3], tm4_r [3], vm4_r [3], wm4_r [3];
  side_t s4_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dm_nxt[i] = MW'(n3_r[i]) * MW'(q3_r[i]);
      tm_nxt[i] = MW'(n3_r[i]) * MW'(p3_r[i]);
      vm_nxt[i] = MW'(e3_r[i]) * MW'(ac3_r[i]);
      wm_nxt[i] = MW'(e3_r[i]) * MW'(ab3_r[i]);
    end
  end

  // ---------------- stage 5: sums ----------------
  logic signed [SW-1:0] d_nxt, tn_nxt, vn_nxt, wn_nxt;
  logic signed [SW-1:0] d5_r, tn5_r, vn5_r, wn5_r;
  side_t s5_nxt, s5_r;

  always_comb begin
    d_nxt  = SW'(dm4_r[0]) + SW'(dm4_r[1]) + SW'(dm4_r[2]);
    tn_nxt = SW'(tm4_r[0]) + SW'(tm4_r[1]) + SW'(tm4_r[2]);
    vn_nxt = SW'(vm4_r[0]) + SW'(vm4_r[1]) + SW'(vm4_r[2]);
    wn_nxt = -(SW'(wm4_r[0]) + SW'(wm4_r[1]) + SW'(wm4_r[2]));
    s5_nxt      = s4_r;
    s5_nxt.back = d_nxt[SW-1];
  end

  // ---------------- stage 6: fold the sign into the numerators ----------------
  logic signed [SW-1:0] d6_nxt, tn6_nxt, vn6_nxt, wn6_nxt;
  logic signed [SW-1:0] d6_r, tn6_r, vn6_r, wn6_r;
  side_t s6_r;

  always_comb begin
    d6_nxt  = s5_r.back ? -d5_r  : d5_r;
    tn6_nxt = s5_r.back ? -tn5_r : tn5_r;
    vn6_nxt = s5_r.back ? -vn5_r : vn5_r;
    wn6_nxt = s5_r.back ? -wn5_r : wn5_r;
  end

  // ---------------- stage 7: hit test and divider set-up ----------------
  logic signed [SW:0]   vw_sum;
  logic [RW-1:0]        t_lhs, t_rhs;
  side_t                s7_nxt;
  logic [RW-1:0]        rem0_nxt [3];
  logic [SW-1:0]        den0_nxt;

  always_comb begin
    vw_sum = (SW+1)'(vn6_r) + (SW+1)'(wn6_r);
    t_lhs  = RW'($unsigned(tn6_r));
    t_rhs  = RW'($unsigned(d6_r)) << SAT_SH;
    s7_nxt     = s6_r;
    s7_nxt.hit = (d6_r != '0) && !tn6_r[SW-1] && !vn6_r[SW-1] && !wn6_r[SW-1]
                 && (vn6_r <= d6_r) && (vw_sum <= (SW+1)'(d6_r));
    s7_nxt.sat = t_lhs >= t_rhs;
    rem0_nxt[0] = RW'($unsigned(tn6_r)) << FRAC_BITS;
    rem0_nxt[1] = RW'($unsigned(vn6_r)) << FRAC_BITS;
    rem0_nxt[2] = RW'($unsigned(wn6_r)) << FRAC_BITS;
    den0_nxt    = $unsigned(d6_r);
  end

  // ---------------- divider pipeline ----------------
  logic [RW-1:0]     dv_rem_r [NSTG+1][3];
  logic [DIST_W-1:0] dv_q_r   [NSTG+1][3];
  logic [SW-1:0]     dv_den_r [NSTG+1];
  side_t             dv_side_r [NSTG+1];

  // ---------------- stage registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
      s4_r.valid <= 1'b0;
      s5_r.valid <= 1'b0;
      s6_r.valid <= 1'b0;
      dv_side_r[0].valid <= 1'b0;
    end else if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s1_r;
      s3_r <= s2_r;
      s4_r <= s3_r;
      s5_r <= s5_nxt;
      s6_r <= s5_r;
      dv_side_r[0] <= s7_nxt;
    end
  end

  // Payload registers advance with the pipeline, no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      ab1_r <= ab_nxt;
      ac1_r <= ac_nxt;
      p1_r  <= p_nxt;
      q1_r  <= q_nxt;
      np2_r <= np_nxt;
      ep2_r <= ep_nxt;
      ab2_r <= ab1_r;
      ac2_r <= ac1_r;
      p2_r  <= p1_r;
      q2_r  <= q1_r;
      n3_r  <= n_nxt;
      e3_r  <= e_nxt;
      ab3_r <= ab2_r;
      ac3_r <= ac2_r;
      p3_r  <= p2_r;
      q3_r  <= q2_r;
      dm4_r <= dm_nxt;
      tm4_r <= tm_nxt;
      vm4_r <= vm_nxt;
      wm4_r <= wm_nxt;
      d5_r  <= d_nxt;
      tn5_r <= tn_nxt;
      vn5_r <= vn_nxt;
      wn5_r <= wn_nxt;
      d6_r  <= d6_nxt;
      tn6_r <= tn6_nxt;
      vn6_r <= vn6_nxt;
      wn6_r <= wn6_nxt;
      dv_rem_r[0] <= rem0_nxt;
      dv_den_r[0] <= den0_nxt;
      for (int k = 0; k < 3; k++) dv_q_r[0][k] <= '0;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar j = 1; j <= NSTG; j++) begin : g_div
    localparam int BIT = NSTG - j;
    logic [RW-1:0]     dsh;
    logic [RW-1:0]     rem_nxt [3];
    logic [DIST_W-1:0] q_nxt   [3];

    always_comb begin
      dsh = RW'(dv_den_r[j-1]) << BIT;
      for (int k = 0; k < 3; k++) begin
        q_nxt[k] = dv_q_r[j-1][k];
        if (dv_rem_r[j-1][k] >= dsh) begin
          rem_nxt[k]    = dv_rem_r[j-1][k] - dsh;
          q_nxt[k][BIT] = 1'b1;
        end else begin
          rem_nxt[k] = dv_rem_r[j-1][k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_side_r[j].valid <= 1'b0;
      end else if (adv) begin
        dv_side_r[j] <= dv_side_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[j] <= rem_nxt;
        dv_q_r[j]   <= q_nxt;
        dv_den_r[j] <= dv_den_r[j-1];
      end
    end
  end

  // ---------------- output register ----------------
  side_t             fin;
  logic [BARY_W-1:0] v_q, w_q;
  out_word_t         out_nxt;
  out_word_t         out_word_r;
  logic              out_valid_r;

  always_comb begin
    fin = dv_side_r[NSTG];
    v_q = dv_q_r[NSTG][1][BARY_W-1:0];
    w_q = dv_q_r[NSTG][2][BARY_W-1:0];
    out_nxt              = '0;
    out_nxt.back_facing  = fin.back;
    out_nxt.face_tag_out = fin.tag;
    if (fin.hit) begin
      out_nxt.hit          = 1'b1;
      out_nxt.hit_distance = fin.sat ? '1 : dv_q_r[NSTG][0];
      out_nxt.bary_v       = v_q;
      out_nxt.bary_w       = w_q;
      out_nxt.bary_u       = ONE_Q - v_q - w_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_word_r <= out_nxt;
  end

  // Hold everything while a finished word waits at the output
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

[rtl/core/rti_checker.sv]
`include "ray_triangle_intersect_top_defines.svh"

module rti_checker #(
  parameter int FRAC_BITS = rti_pkg::FRAC_BITS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input rti_pkg::out_word_t out_word
);
  import rti_pkg::*;

  localparam logic [BARY_W-1:0] ONE_Q = BARY_W'(1 << FRAC_BITS);

  logic [BARY_W-1:0] bary_sum;
  logic              out_waiting;
  logic              miss_clean;

  assign bary_sum    = out_word.bary_u + out_word.bary_v + out_word.bary_w;
  assign out_waiting = out_valid && !out_ready;
  assign miss_clean  = (out_word.hit_distance == '0) && (out_word.bary_u == '0) &&
                       (out_word.bary_v == '0) && (out_word.bary_w == '0);

  // A waiting word stays put until taken
  `RTI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_waiting, out_valid && $stable(out_word))
  // A miss carries no distance and no weights
  `RTI_ASSERT_NOW(a_miss_zero, clk, rst_n, out_valid && !out_word.hit, miss_clean)
  // Weights of a hit add up to one
  `RTI_ASSERT_NOW(a_bary_one, clk, rst_n, out_valid && out_word.hit, bary_sum == ONE_Q)
  // Reset empties the pipeline
  `RTI_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind ray_triangle_intersect_top rti_checker #(.FRAC_BITS(FRAC_BITS)) u_rti_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

[bench/ray_triangle_intersect_top_tb.sv]
module ray_triangle_intersect_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rti_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int PIPE_LAT = 40;

  logic clk;
  logic rst_n;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_word;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [FIELD_W-1:0] cfg_wdata;

  ray_triangle_intersect_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // ray copy held by the predictor
  logic signed [15:0] ray_org [3];
  logic signed [15:0] ray_dir [3];

  in_word_t tri_queue[$];
  out_word_t hit_queue[$];
  int mismatches = 0;
  int words_sent = 0;
  int hits_seen = 0;
  int backs_seen = 0;
  int sends_left = 0;
  bit driver_busy = 1'b0;
  bit in_taken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // append a triangle to the pending queue
  function automatic void enqueue_tri(in_word_t w);
    tri_queue = {tri_queue, w};
  endfunction

  // floor(num * 2^FRAC / den), saturated to 32 bits
  function automatic logic [31:0] fixed_quotient(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    longint unsigned f;
    q = num / den;
    r = num % den;
    f = 0;
    if ((q >> (32 - FRAC)) != 0) return 32'hFFFF_FFFF;
    for (int i = 0; i < FRAC; i++) begin
      r = r << 1;
      f = f << 1;
      if (r >= den) begin
        r = r - den;
        f = f | 1;
      end
    end
    return 32'(((q << FRAC) | f));
  endfunction

  function automatic out_word_t intersect_triangle(in_word_t w);
    longint ax, ay, az, abx, aby, abz, acx, acy, acz;
    longint nx, ny, nz, d, px, py, pz, tn, ex, ey, ez, vn, wn, qx, qy, qz;
    logic [31:0] tq, vq, wq;
    logic [31:0] one;
    out_word_t r;
    ax = w.vert_a_x; ay = w.vert_a_y; az = w.vert_a_z;
    abx = longint'(w.vert_b_x) - ax;
    aby = longint'(w.vert_b_y) - ay;
    abz = longint'(w.vert_b_z) - az;
    acx = longint'(w.vert_c_x) - ax;
    acy = longint'(w.vert_c_y) - ay;
    acz = longint'(w.vert_c_z) - az;
    qx = -longint'(ray_dir[0]);
    qy = -longint'(ray_dir[1]);
    qz = -longint'(ray_dir[2]);
    nx = aby * acz - abz * acy;
    ny = abz * acx - abx * acz;
    nz = abx * acy - aby * acx;
    d = nx * qx + ny * qy + nz * qz;
    px = longint'(ray_org[0]) - ax;
    py = longint'(ray_org[1]) - ay;
    pz = longint'(ray_org[2]) - az;
    tn = px * nx + py * ny + pz * nz;
    ex = qy * pz - qz * py;
    ey = qz * px - qx * pz;
    ez = qx * py - qy * px;
    vn = acx * ex + acy * ey + acz * ez;
    wn = -(abx * ex + aby * ey + abz * ez);
    r = '0;
    r.back_facing = (d < 0);
    r.face_tag_out = w.face_tag;
    if (d < 0) begin
      d = -d; tn = -tn; vn = -vn; wn = -wn;
    end
    if (d != 0 && tn >= 0 && vn >= 0 && vn <= d && wn >= 0 && vn + wn <= d) begin
      tq = fixed_quotient(tn, d);
      vq = fixed_quotient(vn, d);
      wq = fixed_quotient(wn, d);
      one = 32'd1 << FRAC;
      r.hit = 1'b1;
      r.hit_distance = tq;
      r.bary_v = vq[BARY_W-1:0];
      r.bary_w = wq[BARY_W-1:0];
      r.bary_u = 17'(one - vq - wq);
    end
    return r;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3: return 16'($signed($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  // triangle around a point on the ray, mostly hitting
  function automatic in_word_t aimed_triangle();
    in_word_t w;
    int s, cx, cy, cz;
    s = $urandom_range(1, 60);
    cx = ray_org[0] + s * ray_dir[0];
    cy = ray_org[1] + s * ray_dir[1];
    cz = ray_org[2] + s * ray_dir[2];
    w.vert_a_x = 16'(cx + $urandom_range(0, 300) - 150);
    w.vert_a_y = 16'(cy + $urandom_range(0, 300) - 250);
    w.vert_a_z = 16'(cz + $urandom_range(0, 300) - 150);
    w.vert_b_x = 16'(cx + $urandom_range(0, 300) - 50);
    w.vert_b_y = 16'(cy + $urandom_range(0, 300) + 50);
    w.vert_b_z = 16'(cz + $urandom_range(0, 300) - 150);
    w.vert_c_x = 16'(cx + $urandom_range(0, 300) - 250);
    w.vert_c_y = 16'(cy + $urandom_range(0, 300) + 50);
    w.vert_c_z = 16'(cz + $urandom_range(0, 300) - 150);
    w.face_tag = $urandom;
    return w;
  endfunction

  function automatic in_word_t noise_triangle();
    in_word_t w;
    w.vert_a_x = rand_coord(); w.vert_a_y = rand_coord(); w.vert_a_z = rand_coord();
    w.vert_b_x = rand_coord(); w.vert_b_y = rand_coord(); w.vert_b_z = rand_coord();
    w.vert_c_x = rand_coord(); w.vert_c_y = rand_coord(); w.vert_c_z = rand_coord();
    w.face_tag = $urandom;
    return w;
  endfunction

  function automatic in_word_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                        int cx, int cy, int cz, logic [31:0] tag);
    in_word_t w;
    w.vert_a_x = 16'(ax); w.vert_a_y = 16'(ay); w.vert_a_z = 16'(az);
    w.vert_b_x = 16'(bx); w.vert_b_y = 16'(by); w.vert_b_z = 16'(bz);
    w.vert_c_x = 16'(cx); w.vert_c_y = 16'(cy); w.vert_c_z = 16'(cz);
    w.face_tag = tag;
    return w;
  endfunction

  // record the input handshake at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
    end
  end

  // driver: present queued words at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_taken) begin
      // word taken at the last rising edge
      hit_queue = {hit_queue, intersect_triangle(in_word)};
      words_sent++;
      if (tri_queue.size() > 0 && sends_left == 0) begin
        in_word <= tri_queue.pop_front();
        sends_left = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid && tri_queue.size() > 0) begin
      if (sends_left > 0) begin
        sends_left--;
      end else begin
        in_word <= tri_queue.pop_front();
        in_valid <= 1'b1;
        sends_left = pick_gap();
      end
    end
    driver_busy = in_valid || tri_queue.size() > 0;
  end

  // receiver back-pressure
  int stall_left = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // monitor: compare result words with the oldest prediction
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (hit_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", out_word);
      end else begin
        exp_w = hit_queue.pop_front();
        if (exp_w.hit) hits_seen++;
        if (exp_w.back_facing) backs_seen++;
        if (out_word !== exp_w) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch tag %h: expected %p, got %p", exp_w.face_tag_out, exp_w,
                     out_word);
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_ORIGIN_X: ray_org[0] = val;
      CFG_ORIGIN_Y: ray_org[1] = val;
      CFG_ORIGIN_Z: ray_org[2] = val;
      CFG_DIR_X: ray_dir[0] = val;
      CFG_DIR_Y: ray_dir[1] = val;
      CFG_DIR_Z: ray_dir[2] = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    write_reg(CFG_ORIGIN_X, 16'(ox));
    write_reg(CFG_ORIGIN_Y, 16'(oy));
    write_reg(CFG_ORIGIN_Z, 16'(oz));
    write_reg(CFG_DIR_X, 16'(dx));
    write_reg(CFG_DIR_Y, 16'(dy));
    write_reg(CFG_DIR_Z, 16'(dz));
  endtask

  // wait until every word has been sent and answered
  task automatic drain();
    @(negedge clk);
    while (driver_busy || tri_queue.size() > 0 || in_valid || hit_queue.size() > 0)
      @(negedge clk);
    repeat (PIPE_LAT + 5) @(negedge clk);
  endtask

  initial begin
    #20_000_000;
    $display("ray_triangle_intersect_top_tb: done, errors");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    for (int i = 0; i < 3; i++) begin
      ray_org[i] = 0;
      ray_dir[i] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero direction after reset: every test misses
    enqueue_tri(make_tri(0, 0, 5, 10, 0, 5, 0, 10, 5, 32'h0));
    drain();

    // ray down the z axis: front, back, edges, degenerate, behind, far
    set_ray(1, 1, 0, 0, 0, 1);
    enqueue_tri(make_tri(0, 0, 5, 10, 0, 5, 0, 10, 5, 32'h1));
    enqueue_tri(make_tri(0, 0, 5, 0, 10, 5, 10, 0, 5, 32'h2));
    enqueue_tri(make_tri(1, 1, 5, 10, 1, 5, 1, 10, 5, 32'h3));
    enqueue_tri(make_tri(0, 0, 5, 2, 0, 5, 0, 2, 5, 32'h4));
    enqueue_tri(make_tri(0, 0, 5, 5, 5, 5, 10, 10, 5, 32'h5));
    enqueue_tri(make_tri(0, 0, -5, 10, 0, -5, 0, 10, -5, 32'h6));
    enqueue_tri(make_tri(0, 0, 0, 10, 0, 0, 0, 10, 0, 32'h7));
    enqueue_tri(make_tri(0, 0, 0, 0, 10, 1, 0, 0, 10, 32'h8));
    enqueue_tri(make_tri(-32768, -32768, 32767, 32767, -32768, 32767,
                         -32768, 32767, 32767, 32'hFFFF_FFFF));
    enqueue_tri(make_tri(5, 5, 5, 10, 0, 5, 0, 10, 5, 32'h9));
    drain();
    set_ray(-32768, -32768, -32768, 32767, 32767, 32767);
    enqueue_tri(make_tri(32767, -32768, 0, -32768, 32767, 0, 32767, 32767, 0,
                         32'hA5A5_5A5A));
    enqueue_tri(make_tri(-32768, -32768, -32768, -32768, -32768, -32768,
                         32767, 32767, 32767, 32'h0));
    drain();
    set_ray(0, 0, 0, 1, 0, 0);
    enqueue_tri(make_tri(32767, -100, -100, 32767, 100, -100, 32767, 0, 100,
                         32'hFACE));
    enqueue_tri(make_tri(-32768, -32768, -32768, -32768, 32767, -32768,
                         -32768, 32767, 32767, 32'h1234));
    drain();

    // random phases with a fresh ray each time
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: set_ray(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 20) - 10,
                   $urandom_range(0, 20) - 10, $urandom_range(1, 10));
        1: set_ray($urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000,
                   $urandom_range(0, 2000) - 1000, $urandom_range(0, 200) - 100,
                   $urandom_range(0, 200) - 100, $urandom_range(0, 200) - 100);
        2: set_ray(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom));
        default: set_ray(0, 0, 0, -1, -1, -1);
      endcase
      for (int k = 0; k < 120; k++)
        enqueue_tri($urandom_range(0, 3) == 0 ? noise_triangle() : aimed_triangle());
      drain();
    end

    $display("ray_triangle_intersect_top_tb: %0d triangles over 16 rays, %0d hits, %0d back-facing",
             words_sent, hits_seen, backs_seen);
    if (mismatches == 0 && hit_queue.size() == 0) begin
      $display("ray_triangle_intersect_top_tb: done, clean");
    end else begin
      $display("ray_triangle_intersect_top_tb: %0d mismatches, %0d results missing",
               mismatches, hit_queue.size());
      $display("ray_triangle_intersect_top_tb: done, errors");
    end
    $finish;
  end
endmodule

[ray_triangle_intersect_top.f]
+incdir+rtl/core
rtl/core/rti_pkg.sv
rtl/core/ray_triangle_intersect_top.sv
rtl/core/rti_checker.sv
bench/ray_triangle_intersect_top_tb.sv
